@@ design/lhc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package lhc_pkg;

  // Number of entries in the table.
  localparam int DEPTH    = 16;

  // Fixed field widths of the cache transactions.
  localparam int CMD_W    = 2;
  localparam int KEY_W    = 64;
  localparam int HANDLE_W = 64;
  localparam int CAP_W    = 5;
  localparam int CNT_W    = 5;

  // Command codes carried by in_command.
  typedef enum logic [CMD_W-1:0] {
    CMD_FIND   = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_t;

  // One result transaction as it leaves the block.
  typedef struct packed {
    logic                hit;
    logic [HANDLE_W-1:0] found_handle;
    logic                release_valid;
    logic [HANDLE_W-1:0] release_handle;
    logic [CNT_W-1:0]    entry_count;
    logic                last;
  } res_t;

  // Builds a result transaction from its fields.
  function automatic res_t mk_res(input logic                hit,
                                  input logic [HANDLE_W-1:0] found,
                                  input logic                relv,
                                  input logic [HANDLE_W-1:0] rel,
                                  input logic [CNT_W-1:0]    cnt,
                                  input logic                last);
    res_t r;
    r.hit            = hit;
    r.found_handle   = found;
    r.release_valid  = relv;
    r.release_handle = rel;
    r.entry_count    = cnt;
    r.last           = last;
    return r;
  endfunction

endpackage

`default_nettype wire

@@ design/lru_handle_cache.sv @@
// Fully associative key-to-handle cache with least-recently-used replacement.
// Input channel (in_valid/in_ready): in_command selects find, insert or clear;
// in_key and in_handle carry the tag and the handle to store.
// Result channel (out_valid/out_ready): one or more result transactions per
// input, the final one flagged by out_last. Released handles (replaced on
// insert, evicted, or dropped by clear) appear on out_release_handle.
// Configuration (cfg_valid/cfg_ready): cfg_capacity sets the entry limit,
// zero is taken as one and values above DEPTH as DEPTH; write only when idle.
// Entries live in one RAM that is scanned one slot per cycle. A find or an
// insert of a present key needs a lookup scan and a recency scan. An insert
// of a new key needs a lookup and an add scan, plus one eviction scan per
// evicted entry. A clear needs one eviction scan per held entry.
// The block takes one input transaction at a time; in_ready is high only
// while it is idle.
// After reset the table is empty and the capacity is DEPTH.
// A stalled receiver holds the output register; the sequencer waits before
// presenting the next result, so nothing is lost.
`timescale 1ns / 1ps
`default_nettype none

module lru_handle_cache (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [lhc_pkg::CMD_W-1:0]    in_command,
  input  logic [lhc_pkg::KEY_W-1:0]    in_key,
  input  logic [lhc_pkg::HANDLE_W-1:0] in_handle,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_hit,
  output logic [lhc_pkg::HANDLE_W-1:0] out_found_handle,
  output logic                         out_release_valid,
  output logic [lhc_pkg::HANDLE_W-1:0] out_release_handle,
  output logic [lhc_pkg::CNT_W-1:0]    out_entry_count,
  output logic                         out_last,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [lhc_pkg::CAP_W-1:0]    cfg_capacity
);

  import lhc_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int RW = AW;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int WW = KEY_W + HANDLE_W + RW;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_TOUCH,
    S_EVICT,
    S_ADD,
    S_DECIDE,
    S_EMIT
  } state_t;

  state_t              state_r, state_nxt;
  logic [AW:0]         cnt_r, cnt_nxt;
  logic [CMD_W-1:0]    cmd_r, cmd_nxt;
  logic [KEY_W-1:0]    key_r, key_nxt;
  logic [HANDLE_W-1:0] handle_r, handle_nxt;
  logic                hit_r, hit_nxt;
  logic [AW-1:0]       e_r, e_nxt;
  logic [RW-1:0]       rank_r, rank_nxt;
  logic [HANDLE_W-1:0] old_r, old_nxt;
  logic                free_found_r, free_found_nxt;
  logic [AW-1:0]       free_r, free_nxt;
  logic                emitted_r, emitted_nxt;
  logic [DEPTH-1:0]    vld_r, vld_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [CW-1:0]       cap_r, cap_nxt;
  res_t                pend_r, pend_nxt;
  logic                pend_idle_r, pend_idle_nxt;
  res_t                out_r, out_nxt;
  logic                out_valid_r, out_valid_nxt;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [WW-1:0]       ram_wdata;
  logic [AW-1:0]       ram_raddr;
  logic [WW-1:0]       ram_rdata;

  logic [KEY_W-1:0]    rd_key;
  logic [HANDLE_W-1:0] rd_handle;
  logic [RW-1:0]       rd_rank;
  logic [AW-1:0]       dslot;
  logic                dvld;
  logic                dstage;
  logic                last_cnt;

  // Entry store: key, handle and recency rank of every slot.
  lhc_ram #(
    .WIDTH (WW),
    .DEPTH (DEPTH)
  ) u_entries (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Scan pipeline: address cnt_r is read while slot cnt_r-1 is processed.
  assign ram_raddr = cnt_r[AW-1:0];
  assign dslot     = AW'(cnt_r - 1'b1);
  assign dstage    = (cnt_r != '0);
  assign last_cnt  = (cnt_r == (AW+1)'(DEPTH));
  assign rd_key    = ram_rdata[WW-1 -: KEY_W];
  assign rd_handle = ram_rdata[RW +: HANDLE_W];
  assign rd_rank   = ram_rdata[RW-1:0];
  assign dvld      = vld_r[dslot];

  // Handshake and result ports.
  assign in_ready           = (state_r == S_IDLE);
  assign cfg_ready          = 1'b1;
  assign out_valid          = out_valid_r;
  assign out_hit            = out_r.hit;
  assign out_found_handle   = out_r.found_handle;
  assign out_release_valid  = out_r.release_valid;
  assign out_release_handle = out_r.release_handle;
  assign out_entry_count    = out_r.entry_count;
  assign out_last           = out_r.last;

  // Sequencer: lookup, recency update, eviction and add scans, then results.
  always_comb begin
    logic hit_now;
    hit_now        = hit_r;
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    cmd_nxt        = cmd_r;
    key_nxt        = key_r;
    handle_nxt     = handle_r;
    hit_nxt        = hit_r;
    e_nxt          = e_r;
    rank_nxt       = rank_r;
    old_nxt        = old_r;
    free_found_nxt = free_found_r;
    free_nxt       = free_r;
    emitted_nxt    = emitted_r;
    vld_nxt        = vld_r;
    count_nxt      = count_r;
    cap_nxt        = cap_r;
    pend_nxt       = pend_r;
    pend_idle_nxt  = pend_idle_r;
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r;
    ram_we         = 1'b0;
    ram_waddr      = dslot;
    ram_wdata      = {rd_key, rd_handle, rd_rank};

    // Capacity write, clamped into one to DEPTH.
    if (cfg_valid && cfg_ready) begin
      if (cfg_capacity == '0) begin
        cap_nxt = CW'(1);
      end else if (32'(cfg_capacity) > DEPTH) begin
        cap_nxt = CW'(DEPTH);
      end else begin
        cap_nxt = CW'(cfg_capacity);
      end
    end

    // The output register empties when the receiver takes it.
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt        = in_command;
          key_nxt        = in_key;
          handle_nxt     = in_handle;
          hit_nxt        = 1'b0;
          free_found_nxt = 1'b0;
          emitted_nxt    = 1'b0;
          cnt_nxt        = '0;
          case (in_command)
            CMD_FIND, CMD_INSERT: begin
              state_nxt = S_LOOK;
            end
            CMD_CLEAR: begin
              if (count_r == '0) begin
                pend_nxt      = mk_res(1'b0, '0, 1'b0, '0, CNT_W'(count_r), 1'b1);
                pend_idle_nxt = 1'b1;
                state_nxt     = S_EMIT;
              end else begin
                state_nxt = S_EVICT;
              end
            end
            default: begin
              pend_nxt      = mk_res(1'b0, '0, 1'b0, '0, CNT_W'(count_r), 1'b1);
              pend_idle_nxt = 1'b1;
              state_nxt     = S_EMIT;
            end
          endcase
        end
      end

      S_LOOK: begin
        cnt_nxt = cnt_r + 1'b1;
        if (dstage) begin
          if (dvld && (rd_key == key_r) && !hit_r) begin
            hit_now  = 1'b1;
            hit_nxt  = 1'b1;
            e_nxt    = dslot;
            rank_nxt = rd_rank;
            old_nxt  = rd_handle;
          end
          if (!dvld && !free_found_r) begin
            free_found_nxt = 1'b1;
            free_nxt       = dslot;
          end
        end
        if (last_cnt) begin
          cnt_nxt = '0;
          if (hit_now) begin
            state_nxt = S_TOUCH;
          end else if (cmd_r == CMD_FIND) begin
            pend_nxt      = mk_res(1'b0, '0, 1'b0, '0, CNT_W'(count_r), 1'b1);
            pend_idle_nxt = 1'b1;
            state_nxt     = S_EMIT;
          end else begin
            state_nxt = S_DECIDE;
          end
        end
      end

      // Make the located entry most recent; an insert also swaps its handle.
      S_TOUCH: begin
        cnt_nxt = cnt_r + 1'b1;
        if (dstage && dvld) begin
          if (dslot == e_r) begin
            ram_we    = 1'b1;
            ram_wdata = {rd_key, (cmd_r == CMD_INSERT) ? handle_r : rd_handle, RW'(0)};
          end else if (rd_rank < rank_r) begin
            ram_we    = 1'b1;
            ram_wdata = {rd_key, rd_handle, RW'(rd_rank + 1'b1)};
          end
        end
        if (last_cnt) begin
          cnt_nxt = '0;
          if (cmd_r == CMD_FIND) begin
            pend_nxt      = mk_res(1'b1, old_r, 1'b0, '0, CNT_W'(count_r), 1'b1);
            pend_idle_nxt = 1'b1;
          end else begin
            pend_nxt      = mk_res(1'b0, '0, 1'b1, old_r, CNT_W'(count_r),
                                   count_r <= cap_r);
            pend_idle_nxt = (count_r <= cap_r);
          end
          emitted_nxt = 1'b1;
          state_nxt   = S_EMIT;
        end
      end

      // Remove the least recent entry and hand back its handle.
      S_EVICT: begin
        cnt_nxt = cnt_r + 1'b1;
        if (dstage && dvld && (rd_rank == RW'(count_r - 1'b1))) begin
          vld_nxt[dslot] = 1'b0;
          count_nxt      = count_r - 1'b1;
          free_nxt       = dslot;
          emitted_nxt    = 1'b1;
          cnt_nxt        = '0;
          state_nxt      = S_EMIT;
          if (cmd_r == CMD_CLEAR) begin
            pend_nxt      = mk_res(1'b0, '0, 1'b1, rd_handle, CNT_W'(count_nxt),
                                   count_r == CW'(1));
            pend_idle_nxt = (count_r == CW'(1));
          end else if (hit_r) begin
            pend_nxt      = mk_res(1'b0, '0, 1'b1, rd_handle, CNT_W'(count_nxt),
                                   count_nxt <= cap_r);
            pend_idle_nxt = (count_nxt <= cap_r);
          end else begin
            // A new key still follows, so its slot is counted as held.
            pend_nxt      = mk_res(1'b0, '0, 1'b1, rd_handle, CNT_W'(count_r),
                                   count_r <= cap_r);
            pend_idle_nxt = 1'b0;
          end
        end else if (last_cnt) begin
          cnt_nxt   = '0;
          state_nxt = S_IDLE;
        end
      end

      // Choose the next scan of an insert or a clear.
      S_DECIDE: begin
        cnt_nxt = '0;
        case (cmd_r)
          CMD_INSERT: begin
            if (hit_r) begin
              state_nxt = (count_r > cap_r) ? S_EVICT : S_IDLE;
            end else if ((count_r != '0) && (count_r >= cap_r)) begin
              state_nxt = S_EVICT;
            end else begin
              state_nxt = S_ADD;
            end
          end
          CMD_CLEAR: begin
            state_nxt = (count_r != '0) ? S_EVICT : S_IDLE;
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end

      // Age every held entry and write the new one as most recent.
      S_ADD: begin
        cnt_nxt = cnt_r + 1'b1;
        if (dstage) begin
          if (dslot == free_r) begin
            ram_we         = 1'b1;
            ram_wdata      = {key_r, handle_r, RW'(0)};
            vld_nxt[dslot] = 1'b1;
            count_nxt      = count_r + 1'b1;
          end else if (dvld) begin
            ram_we    = 1'b1;
            ram_wdata = {rd_key, rd_handle, RW'(rd_rank + 1'b1)};
          end
        end
        if (last_cnt) begin
          cnt_nxt = '0;
          if (emitted_r) begin
            state_nxt = S_IDLE;
          end else begin
            pend_nxt      = mk_res(1'b0, '0, 1'b0, '0, CNT_W'(count_nxt), 1'b1);
            pend_idle_nxt = 1'b1;
            state_nxt     = S_EMIT;
          end
        end
      end

      // Hand the pending result to the output register once it is free.
      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_nxt       = pend_r;
          out_valid_nxt = 1'b1;
          state_nxt     = pend_idle_r ? S_IDLE : S_DECIDE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State, table status and registered outputs.
  always_ff @(posedge clk) begin
    key_r       <= key_nxt;
    handle_r    <= handle_nxt;
    e_r         <= e_nxt;
    rank_r      <= rank_nxt;
    old_r       <= old_nxt;
    free_r      <= free_nxt;
    cmd_r       <= cmd_nxt;
    pend_r      <= pend_nxt;
    pend_idle_r <= pend_idle_nxt;
    out_r       <= out_nxt;
    cnt_r       <= cnt_nxt;
    if (!rst_n) begin
      state_r      <= S_IDLE;
      hit_r        <= 1'b0;
      free_found_r <= 1'b0;
      emitted_r    <= 1'b0;
      vld_r        <= '0;
      count_r      <= '0;
      cap_r        <= CW'(DEPTH);
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      hit_r        <= hit_nxt;
      free_found_r <= free_found_nxt;
      emitted_r    <= emitted_nxt;
      vld_r        <= vld_nxt;
      count_r      <= count_nxt;
      cap_r        <= cap_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

`ifndef SYNTH
  // The entry count never exceeds the table depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count above table depth");

  // Between transactions the valid bits agree with the entry count.
  a_valid_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> ($countones(vld_r) == int'(count_r)))
    else $error("valid bits disagree with entry count");

  // The stored capacity always lies between one and the depth.
  a_cap_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cap_r != '0) && (cap_r <= CW'(DEPTH)))
    else $error("capacity out of range");

  // An accepted transaction keeps the block busy in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted twice in a row");

  // The entry store is never written while the block is idle.
  a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !ram_we)
    else $error("entry store written while idle");
`endif

endmodule

`default_nettype wire

@@ design/lhc_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module lhc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one read port with registered read data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ verif/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import lhc_pkg::*;

  localparam int QUIET_LIMIT = 5000;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 36;
  localparam int POOL_SIZE   = 24;

  // The fourth command code has no operation behind it.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  localparam logic [KEY_W-1:0] ALL_ONES = {KEY_W{1'b1}};
  localparam logic [KEY_W-1:0] ALT_5    = 64'h5555_5555_5555_5555;
  localparam logic [KEY_W-1:0] ALT_A    = 64'hAAAA_AAAA_AAAA_AAAA;

  // One row of the directed stimulus: a capacity write or a cache transaction.
  typedef struct {
    bit                  is_cfg;
    logic [CAP_W-1:0]    cap;
    logic [CMD_W-1:0]    cmd;
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] hdl;
    bit                  typed;
    res_t                want;
  } stim_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [CMD_W-1:0]    in_command = CMD_FIND;
  logic [KEY_W-1:0]    in_key = '0;
  logic [HANDLE_W-1:0] in_handle = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                out_hit;
  logic [HANDLE_W-1:0] out_found_handle;
  logic                out_release_valid;
  logic [HANDLE_W-1:0] out_release_handle;
  logic [CNT_W-1:0]    out_entry_count;
  logic                out_last;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CAP_W-1:0]    cfg_capacity = '0;

  // Predicted cache contents.
  logic [KEY_W-1:0]    tag_mem [DEPTH];
  logic [HANDLE_W-1:0] hdl_mem [DEPTH];
  bit                  slot_used [DEPTH];
  int                  age [DEPTH];
  int                  held;
  int                  cap_limit;

  res_t                pending_results [$];
  res_t                want_res;
  stim_row_t           stim_rows [$];
  logic [KEY_W-1:0]    key_pool [POOL_SIZE];
  int                  errors = 0;
  int                  idle_pct = 0;
  int                  stall_pct = 0;
  int                  quiet = 0;

  lru_handle_cache dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_command         (in_command),
    .in_key             (in_key),
    .in_handle          (in_handle),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_hit            (out_hit),
    .out_found_handle   (out_found_handle),
    .out_release_valid  (out_release_valid),
    .out_release_handle (out_release_handle),
    .out_entry_count    (out_entry_count),
    .out_last           (out_last),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_capacity       (cfg_capacity)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Table building.
  function automatic void add_op(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
                                 input logic [HANDLE_W-1:0] hdl);
    stim_row_t r;
    r.is_cfg = 1'b0;
    r.cap    = '0;
    r.cmd    = cmd;
    r.key    = key;
    r.hdl    = hdl;
    r.typed  = 1'b0;
    r.want   = '0;
    stim_rows.insert(stim_rows.size(), r);
  endfunction

  function automatic void add_typed(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
                                    input logic [HANDLE_W-1:0] hdl, input res_t want);
    add_op(cmd, key, hdl);
    stim_rows[stim_rows.size()-1].typed = 1'b1;
    stim_rows[stim_rows.size()-1].want  = want;
  endfunction

  function automatic void add_cfg(input logic [CAP_W-1:0] cap);
    add_op(CMD_FIND, '0, '0);
    stim_rows[stim_rows.size()-1].is_cfg = 1'b1;
    stim_rows[stim_rows.size()-1].cap    = cap;
  endfunction

  // Predictor: recency helpers and one step of the cache.
  function automatic void promote(input int e);
    for (int i = 0; i < DEPTH; i++)
      if (slot_used[i] && age[i] < age[e]) age[i]++;
    age[e] = 0;
  endfunction

  // Frees the least recent slot and returns it, or -1 if none matches.
  function automatic int drop_oldest();
    for (int i = 0; i < DEPTH; i++) begin
      if (slot_used[i] && age[i] + 1 == held) begin
        slot_used[i] = 1'b0;
        held--;
        return i;
      end
    end
    return -1;
  endfunction

  function automatic void note_result(input logic hit, input logic [HANDLE_W-1:0] found,
                                      input logic relv, input logic [HANDLE_W-1:0] rel,
                                      input int cnt);
    res_t r;
    r.hit            = hit;
    r.found_handle   = found;
    r.release_valid  = relv;
    r.release_handle = rel;
    r.entry_count    = cnt[CNT_W-1:0];
    r.last           = 1'b0;
    pending_results.insert(pending_results.size(), r);
  endfunction

  function automatic int predict_cache_op(input logic [CMD_W-1:0] cmd,
                                          input logic [KEY_W-1:0] key,
                                          input logic [HANDLE_W-1:0] hdl);
    int                  e;
    int                  v;
    int                  fr;
    int                  n0;
    logic [HANDLE_W-1:0] old;
    n0 = pending_results.size();
    e  = -1;
    for (int i = 0; i < DEPTH; i++)
      if (e < 0 && slot_used[i] && tag_mem[i] == key) e = i;
    case (cmd)
      CMD_FIND: begin
        if (e >= 0) begin
          promote(e);
          note_result(1'b1, hdl_mem[e], 1'b0, '0, held);
        end else begin
          note_result(1'b0, '0, 1'b0, '0, held);
        end
      end
      CMD_INSERT: begin
        if (e >= 0) begin
          // Present key: hand back the old handle, then trim to capacity.
          old = hdl_mem[e];
          hdl_mem[e] = hdl;
          promote(e);
          note_result(1'b0, '0, 1'b1, old, held);
          while (held > cap_limit) begin
            v = drop_oldest();
            if (v < 0) break;
            note_result(1'b0, '0, 1'b1, hdl_mem[v], held);
          end
        end else begin
          // New key: make room first, reporting the count with the new entry.
          while (held > 0 && held + 1 > cap_limit) begin
            v = drop_oldest();
            if (v < 0) break;
            note_result(1'b0, '0, 1'b1, hdl_mem[v], held + 1);
          end
          fr = -1;
          for (int i = 0; i < DEPTH; i++)
            if (fr < 0 && !slot_used[i]) fr = i;
          if (fr >= 0) begin
            for (int i = 0; i < DEPTH; i++)
              if (slot_used[i]) age[i]++;
            slot_used[fr] = 1'b1;
            tag_mem[fr]   = key;
            hdl_mem[fr]   = hdl;
            age[fr]       = 0;
            held++;
          end
          if (pending_results.size() == n0) note_result(1'b0, '0, 1'b0, '0, held);
        end
      end
      CMD_CLEAR: begin
        while (held > 0) begin
          v = drop_oldest();
          if (v < 0) break;
          note_result(1'b0, '0, 1'b1, hdl_mem[v], held);
        end
        for (int i = 0; i < DEPTH; i++) slot_used[i] = 1'b0;
        held = 0;
        if (pending_results.size() == n0) note_result(1'b0, '0, 1'b0, '0, held);
      end
      default: note_result(1'b0, '0, 1'b0, '0, held);
    endcase
    pending_results[pending_results.size()-1].last = 1'b1;
    return pending_results.size() - n0;
  endfunction

  // Mismatch reporting.
  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    errors++;
    if (errors <= 100)
      $display("%0t ns: %s mismatch: got %h, expected %h", $time, what, got, want);
  endtask

  // Waits at least one cycle, then until every predicted result has arrived.
  task automatic wait_drained();
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // Capacity writes happen only with the block idle.
  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    in_valid <= 1'b0;
    wait_drained();
    // The final result can leave before the closing table scan has ended.
    while (!in_ready) @(posedge clk);
    cfg_valid    <= 1'b1;
    cfg_capacity <= cap;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (cap == 0) cap_limit = 1;
    else if (cap > DEPTH) cap_limit = DEPTH;
    else cap_limit = int'(cap);
  endtask

  // Presents one transaction, with an optional gap before it, and waits for acceptance.
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
                           input logic [HANDLE_W-1:0] hdl);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid   <= 1'b1;
    in_command <= cmd;
    in_key     <= key;
    in_handle  <= hdl;
    do @(posedge clk); while (!in_ready);
  endtask

  // Receiver back-pressure.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Result checking against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, entry_count", 64'(out_entry_count), '0);
      end else begin
        want_res = pending_results.pop_front();
        if (out_hit !== want_res.hit)
          report_mismatch("hit", 64'(out_hit), 64'(want_res.hit));
        if (out_found_handle !== want_res.found_handle)
          report_mismatch("found_handle", out_found_handle, want_res.found_handle);
        if (out_release_valid !== want_res.release_valid)
          report_mismatch("release_valid", 64'(out_release_valid),
                          64'(want_res.release_valid));
        if (out_release_handle !== want_res.release_handle)
          report_mismatch("release_handle", out_release_handle, want_res.release_handle);
        if (out_entry_count !== want_res.entry_count)
          report_mismatch("entry_count", 64'(out_entry_count), 64'(want_res.entry_count));
        if (out_last !== want_res.last)
          report_mismatch("last", 64'(out_last), 64'(want_res.last));
      end
    end
  end

  // Watchdog: ends the run after too long without any transaction.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Stimulus sequence.
  initial begin
    int               nres;
    int               r;
    logic [CMD_W-1:0] cmd;
    logic [KEY_W-1:0] key;
    res_t             drop;
    logic [CAP_W-1:0] phase_caps [PHASES];

    phase_caps = '{5'd3, 5'd0, 5'd16, 5'd31, 5'd1, 5'd2, 5'd17, 5'd8};
    for (int i = 0; i < DEPTH; i++) begin
      slot_used[i] = 1'b0;
      age[i]       = 0;
      tag_mem[i]   = '0;
      hdl_mem[i]   = '0;
    end
    held      = 0;
    cap_limit = DEPTH;

    // Directed part: empty table, unused command, extremes of key and handle,
    // replacement, lowered capacity, eviction and clear.
    add_typed(CMD_FIND, '0, '0, mk_res(1'b0, '0, 1'b0, '0, 5'd0, 1'b1));
    add_typed(CMD_CLEAR, ALL_ONES, ALL_ONES, mk_res(1'b0, '0, 1'b0, '0, 5'd0, 1'b1));
    add_typed(CMD_UNUSED, ALL_ONES, '0, mk_res(1'b0, '0, 1'b0, '0, 5'd0, 1'b1));
    add_typed(CMD_INSERT, ALL_ONES, ALL_ONES, mk_res(1'b0, '0, 1'b0, '0, 5'd1, 1'b1));
    add_typed(CMD_INSERT, '0, '0, mk_res(1'b0, '0, 1'b0, '0, 5'd2, 1'b1));
    add_typed(CMD_FIND, ALL_ONES, '0, mk_res(1'b1, ALL_ONES, 1'b0, '0, 5'd2, 1'b1));
    add_typed(CMD_FIND, '0, ALL_ONES, mk_res(1'b1, '0, 1'b0, '0, 5'd2, 1'b1));
    add_typed(CMD_INSERT, ALL_ONES, ALT_5, mk_res(1'b0, '0, 1'b1, ALL_ONES, 5'd2, 1'b1));
    add_op(CMD_INSERT, ALT_A, 64'h1);
    add_op(CMD_INSERT, 64'h8000_0000_0000_0001, 64'h8000_0000_0000_0000);
    add_op(CMD_UNUSED, '0, '0);
    add_op(CMD_FIND, 64'h1234, '0);
    add_cfg(5'd0);
    add_op(CMD_FIND, '0, '0);
    add_op(CMD_INSERT, 64'h1234, 64'hDEAD_BEEF_0BAD_F00D);
    add_op(CMD_INSERT, 64'h1234, 64'h0123_4567_89AB_CDEF);
    add_cfg(5'd31);
    add_op(CMD_INSERT, 64'h0F0F_0F0F_0F0F_0F0F, 64'hF0F0_F0F0_F0F0_F0F0);
    add_op(CMD_INSERT, 64'hF0F0_F0F0_F0F0_F0F0, 64'h0F0F_0F0F_0F0F_0F0F);
    add_op(CMD_INSERT, 64'h0000_0001_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF);
    add_op(CMD_INSERT, 64'h7FFF_FFFF_FFFF_FFFF, 64'h0000_0001_0000_0000);
    add_cfg(5'd2);
    add_op(CMD_INSERT, 64'h1234, 64'h42);
    add_op(CMD_FIND, 64'h0F0F_0F0F_0F0F_0F0F, '0);
    add_op(CMD_CLEAR, '0, '0);
    add_cfg(5'd17);
    add_op(CMD_INSERT, ALL_ONES, '0);
    add_op(CMD_CLEAR, '0, '0);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (stim_rows[i]) begin
      if (stim_rows[i].is_cfg) begin
        write_capacity(stim_rows[i].cap);
      end else begin
        send_item(stim_rows[i].cmd, stim_rows[i].key, stim_rows[i].hdl);
        nres = predict_cache_op(stim_rows[i].cmd, stim_rows[i].key, stim_rows[i].hdl);
        // Rows with a typed result replace the prediction with it.
        if (stim_rows[i].typed) begin
          repeat (nres) drop = pending_results.pop_back();
          pending_results.insert(pending_results.size(), stim_rows[i].want);
        end
      end
    end

    // Random part: each phase sets a capacity and an idling pattern.
    for (int ph = 0; ph < PHASES; ph++) begin
      write_capacity(phase_caps[ph]);
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 88; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 88; end
        default: begin idle_pct = 33; stall_pct = 33; end
      endcase
      for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = {$urandom, $urandom};
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Once, let the block run dry before carrying on.
        if (ph == 1 && n == 20) begin
          in_valid <= 1'b0;
          wait_drained();
        end
        r = $urandom_range(99);
        if (r < 44) cmd = CMD_FIND;
        else if (r < 90) cmd = CMD_INSERT;
        else if (r < 95) cmd = CMD_CLEAR;
        else cmd = CMD_UNUSED;
        if ($urandom_range(99) < 85) key = key_pool[$urandom_range(POOL_SIZE-1)];
        else key = {$urandom, $urandom};
        send_item(cmd, key, {$urandom, $urandom});
        nres = predict_cache_op(cmd, key, in_handle);
      end
    end

    in_valid <= 1'b0;
    wait_drained();
    repeat (2*DEPTH + 8) @(posedge clk);
    if (errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
